// File: sv/compax_bitmap_word_encoder_core_assert.svh
// ----------------------------------------------------------------------------
// COMPAX bitmap word encoder - assertion macros
// Shorthand for the concurrent checks bound to the encoder core.
// ----------------------------------------------------------------------------
`ifndef COMPAX_BITMAP_WORD_ENCODER_CORE_ASSERT_SVH
`define COMPAX_BITMAP_WORD_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CBWE_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define CBWE_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication, always active (used for reset behavior).
`define CBWE_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/cbwe_pkg.sv
// ----------------------------------------------------------------------------
// COMPAX bitmap word encoder - package
// Shared types, codes, constants and byte helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package cbwe_pkg;

    // Input item kinds (carried on s_tuser)
    localparam logic [1:0] MODE_LIT   = 2'd0;
    localparam logic [1:0] MODE_ZERO  = 2'd1;
    localparam logic [1:0] MODE_ONE   = 2'd2;
    localparam logic [1:0] MODE_FLUSH = 2'd3;

    localparam logic [31:0] FILL_MAX   = 32'h1FFF_FFFF;
    localparam logic [31:0] SHORT_LIM  = 32'h0000_0100;
    localparam logic [31:0] LFL_FLAG   = 32'h2000_0000;
    localparam logic [31:0] FLF_FLAG   = 32'h4000_0000;
    localparam logic [7:0]  BYTE_FULL  = 8'hFF;
    localparam logic [31:0] ONES_WORD  = 32'hFFFF_FFFF;
    localparam logic [31:0] FILL_ONE   = 32'h0000_0001;

    // Byte offset codes; OFF_NONE means the payload spans more than one byte
    localparam logic [2:0] OFF_NONE = 3'd4;

    typedef enum logic [5:0] {
        ST_NONE = 6'b000001,
        ST_LIT  = 6'b000010,
        ST_FILL = 6'b000100,
        ST_LF   = 6'b001000,
        ST_FL   = 6'b010000,
        ST_FLF  = 6'b100000
    } enc_state_t;

    typedef logic [2:0][31:0] word3_t;

    // Words leaving the encoder after one step, oldest in slot 0
    typedef struct packed {
        word3_t     words;
        logic [2:0] last;
        logic [1:0] count;
    } emit_t;

    function automatic logic [2:0] byte_offset(input logic [31:0] w);
        logic [30:0] v;
        logic [2:0]  off;
        v = w[30:0];
        if (v[30:8] == 23'd0) begin
            off = 3'd0;
        end else if (v[30:16] == 15'd0 && v[7:0] == 8'd0) begin
            off = 3'd1;
        end else if (v[30:24] == 7'd0 && v[15:0] == 16'd0) begin
            off = 3'd2;
        end else if (v[23:0] == 24'd0) begin
            off = 3'd3;
        end else begin
            off = OFF_NONE;
        end
        return off;
    endfunction

    function automatic logic [7:0] byte_at(input logic [31:0] w, input logic [1:0] off);
        logic [7:0] b;
        case (off)
            2'd0:    b = w[7:0];
            2'd1:    b = w[15:8];
            2'd2:    b = w[23:16];
            default: b = w[31:24];
        endcase
        return b;
    endfunction

    function automatic logic [1:0] held_need(input enc_state_t st);
        logic [1:0] n;
        case (st)
            ST_LIT, ST_FILL, ST_FLF: n = 2'd1;
            ST_LF, ST_FL:            n = 2'd2;
            default:                 n = 2'd0;
        endcase
        return n;
    endfunction

endpackage

`default_nettype wire

// File: sv/cbwe_step.sv
// ----------------------------------------------------------------------------
// COMPAX bitmap word encoder - step logic
// One item applied to the held tail words: push, extend, merge and emit.
// ----------------------------------------------------------------------------
`default_nettype none

module cbwe_step (
    input  wire logic [1:0]           mode,
    input  wire logic [31:0]          word,
    input  wire cbwe_pkg::enc_state_t st,
    input  wire logic [1:0]           cnt,
    input  wire cbwe_pkg::word3_t     tail,
    output cbwe_pkg::enc_state_t      st_next,
    output logic [1:0]                cnt_next,
    output cbwe_pkg::word3_t          tail_next,
    output cbwe_pkg::emit_t           emit
);

    logic [1:0]           last_idx;
    logic [31:0]          last_w;
    logic [31:0]          last_inc;
    logic                 push_en;
    logic [31:0]          push_val;
    logic                 inc_en;
    logic                 do_lfl;
    logic                 do_flf;
    cbwe_pkg::enc_state_t s;
    cbwe_pkg::word3_t     a;
    logic [1:0]           c;
    logic [2:0]           off0;
    logic [2:0]           off1;
    logic [2:0]           off2;
    logic [31:0]          m_lfl;
    logic [31:0]          m_flf;
    logic [1:0]           need;
    logic [1:0]           n;
    logic                 is_flush;

    assign last_idx = cnt - 2'd1;
    assign last_w   = tail[last_idx];
    assign last_inc = last_w + 32'd1;
    assign is_flush = (mode == cbwe_pkg::MODE_FLUSH);

    // Decide push / increment / merge
    always_comb begin
        push_en  = 1'b0;
        push_val = cbwe_pkg::FILL_ONE;
        inc_en   = 1'b0;
        do_lfl   = 1'b0;
        do_flf   = 1'b0;
        s        = cbwe_pkg::ST_LIT;
        case (mode)
            cbwe_pkg::MODE_ONE: begin
                push_en  = 1'b1;
                push_val = cbwe_pkg::ONES_WORD;
                s        = cbwe_pkg::ST_LIT;
            end
            cbwe_pkg::MODE_ZERO: begin
                case (st)
                    cbwe_pkg::ST_LIT: begin
                        push_en = 1'b1;
                        s       = cbwe_pkg::ST_LF;
                    end
                    cbwe_pkg::ST_FILL, cbwe_pkg::ST_LF: begin
                        s = st;
                        if (cnt == 2'd0 || last_w >= cbwe_pkg::FILL_MAX) begin
                            push_en = 1'b1;
                        end else begin
                            inc_en = 1'b1;
                        end
                    end
                    cbwe_pkg::ST_FL: begin
                        push_en = 1'b1;
                        do_flf  = 1'b1;
                    end
                    cbwe_pkg::ST_FLF: begin
                        if (cnt == 2'd0 || last_w[7:0] == cbwe_pkg::BYTE_FULL) begin
                            push_en = 1'b1;
                            s       = cbwe_pkg::ST_FILL;
                        end else begin
                            inc_en = 1'b1;
                            s      = cbwe_pkg::ST_FLF;
                        end
                    end
                    default: begin
                        push_en = 1'b1;
                        s       = cbwe_pkg::ST_FILL;
                    end
                endcase
            end
            cbwe_pkg::MODE_LIT: begin
                push_en  = 1'b1;
                push_val = word;
                case (st)
                    cbwe_pkg::ST_FILL: s = cbwe_pkg::ST_FL;
                    cbwe_pkg::ST_LF:   do_lfl = 1'b1;
                    default:           s = cbwe_pkg::ST_LIT;
                endcase
            end
            default: begin
                s = cbwe_pkg::ST_NONE;
            end
        endcase
    end

    // Merged words, built from the three slots after the push
    always_comb begin
        m_lfl = {3'b000, off0[1:0], off2[1:0], 1'b0, cbwe_pkg::byte_at(a[0], off0[1:0]),
                 a[1][7:0], cbwe_pkg::byte_at(a[2], off2[1:0])} | cbwe_pkg::LFL_FLAG;
        m_flf = {3'b000, off1[1:0], 3'b000, a[0][7:0],
                 cbwe_pkg::byte_at(a[1], off1[1:0]), a[2][7:0]} | cbwe_pkg::FLF_FLAG;
    end

    assign off0 = cbwe_pkg::byte_offset(a[0]);
    assign off1 = cbwe_pkg::byte_offset(a[1]);
    assign off2 = cbwe_pkg::byte_offset(a[2]);

    // Apply push / increment, then merge
    cbwe_pkg::word3_t     pa;
    logic [1:0]           pc;

    always_comb begin
        pa = tail;
        pc = cnt;
        if (push_en && cnt != 2'd3) begin
            pa[cnt] = push_val;
            pc      = cnt + 2'd1;
        end
        if (inc_en) begin
            pa[last_idx] = last_inc;
        end
    end

    always_comb begin
        a       = pa;
        c       = pc;
        st_next = s;
        if (do_lfl) begin
            if (c != 2'd3 || a[1] >= cbwe_pkg::SHORT_LIM) begin
                st_next = cbwe_pkg::ST_LIT;
            end else if (off2 == cbwe_pkg::OFF_NONE) begin
                st_next = cbwe_pkg::ST_NONE;
            end else if (off0 == cbwe_pkg::OFF_NONE) begin
                st_next = cbwe_pkg::ST_FL;
            end else begin
                st_next = cbwe_pkg::ST_NONE;
            end
        end else if (do_flf) begin
            if (c != 2'd3) begin
                st_next = cbwe_pkg::ST_FILL;
            end else if (a[2] >= cbwe_pkg::SHORT_LIM) begin
                st_next = cbwe_pkg::ST_NONE;
            end else if (off1 == cbwe_pkg::OFF_NONE) begin
                st_next = cbwe_pkg::ST_FILL;
            end else if (a[0] >= cbwe_pkg::SHORT_LIM) begin
                st_next = cbwe_pkg::ST_LF;
            end else begin
                st_next = cbwe_pkg::ST_FLF;
            end
        end
        if (is_flush) begin
            st_next = cbwe_pkg::ST_NONE;
        end
    end

    // Merge success collapses three slots into slot 0
    logic                 lfl_ok;
    logic                 flf_ok;
    cbwe_pkg::word3_t     ma;
    logic [1:0]           mc;

    assign lfl_ok = do_lfl && pc == 2'd3 && pa[1] < cbwe_pkg::SHORT_LIM
                    && off2 != cbwe_pkg::OFF_NONE && off0 != cbwe_pkg::OFF_NONE;
    assign flf_ok = do_flf && pc == 2'd3 && pa[2] < cbwe_pkg::SHORT_LIM
                    && off1 != cbwe_pkg::OFF_NONE && pa[0] < cbwe_pkg::SHORT_LIM;

    always_comb begin
        ma = pa;
        mc = pc;
        if (lfl_ok) begin
            ma[0] = m_lfl;
            mc    = 2'd1;
        end else if (flf_ok) begin
            ma[0] = m_flf;
            mc    = 2'd1;
        end
    end

    // Emit oldest words down to the count the new state keeps
    assign need = cbwe_pkg::held_need(st_next);

    always_comb begin
        n          = (mc > need) ? (mc - need) : 2'd0;
        emit.words = ma;
        emit.last  = 3'b000;
        emit.count = n;
        cnt_next   = mc - n;
        case (n)
            2'd1:    tail_next = {ma[2], ma[2], ma[1]};
            2'd2:    tail_next = {ma[2], ma[2], ma[2]};
            default: tail_next = ma;
        endcase
        if (is_flush) begin
            emit.words = tail;
            emit.count = cnt;
            case (cnt)
                2'd1:    emit.last = 3'b001;
                2'd2:    emit.last = 3'b010;
                2'd3:    emit.last = 3'b100;
                default: emit.last = 3'b000;
            endcase
            cnt_next  = 2'd0;
            tail_next = tail;
        end
    end

endmodule

`default_nettype wire

// File: sv/cbwe_outq.sv
// ----------------------------------------------------------------------------
// COMPAX bitmap word encoder - result queue
// Holds up to three finished words and hands them out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module cbwe_outq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            load,
    input  wire cbwe_pkg::emit_t emit,
    output logic                 load_ok,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic [31:0]          m_tdata,
    output logic                 m_tlast
);

    cbwe_pkg::word3_t pend_words_reg;
    cbwe_pkg::word3_t pend_words_next;
    logic [2:0]       pend_last_reg;
    logic [2:0]       pend_last_next;
    logic [1:0]       pend_cnt_reg;
    logic [1:0]       pend_cnt_next;
    logic             pop;

    assign m_tvalid = (pend_cnt_reg != 2'd0);
    assign m_tdata  = pend_words_reg[0];
    assign m_tlast  = pend_last_reg[0];
    assign pop      = m_tvalid && m_tready;
    // Load only when the queue is, or is about to be, empty
    assign load_ok  = (pend_cnt_reg == 2'd0) || (pend_cnt_reg == 2'd1 && m_tready);

    always_comb begin
        pend_words_next = pend_words_reg;
        pend_last_next  = pend_last_reg;
        pend_cnt_next   = pend_cnt_reg;
        if (load) begin
            pend_words_next = emit.words;
            pend_last_next  = emit.last;
            pend_cnt_next   = emit.count;
        end else if (pop) begin
            pend_words_next = {pend_words_reg[2], pend_words_reg[2], pend_words_reg[1]};
            pend_last_next  = {1'b0, pend_last_reg[2:1]};
            pend_cnt_next   = pend_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_cnt_reg <= 2'd0;
        end else begin
            pend_cnt_reg <= pend_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_words_reg <= pend_words_next;
        pend_last_reg  <= pend_last_next;
    end

endmodule

`default_nettype wire

// File: sv/compax_bitmap_word_encoder_core.sv
// ----------------------------------------------------------------------------
// COMPAX bitmap word encoder core
// Compresses a stream of 31-bit bitmap chunks into COMPAX words.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side takes one chunk per transfer: s_tuser = kind (literal, zero
//   fill, one fill, flush), s_tdata = literal word (used for literals only).
//   Master side gives one compressed word per transfer on m_tdata; m_tlast
//   marks the final word drained by a flush. A flush with nothing held gives
//   no transfer.
//   Timing: a chunk is registered at its input transfer and applied from the
//   input register once the result queue can take its words, which loads
//   them into the result queue; the first word then shows on m_tvalid from
//   the result queue register.
//   Throughput: one chunk per cycle while m_tready is high and each chunk
//   releases at most one word; a chunk releasing n words (up to three) holds
//   the queue until they drain, the next chunk waiting in the input register.
//   Stall: when m_tready is low the result queue holds its words, the input
//   register fills and s_tready drops; nothing is lost.
//   Reset (aresetn low, synchronous): encoder returns to the empty state,
//   queues are emptied, m_tvalid low and s_tready high on release.
// ----------------------------------------------------------------------------
`default_nettype none

module compax_bitmap_word_encoder_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input chunks
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,    // [31:0] literal_word
    input  wire logic [1:0]  s_tuser,    // [1:0] mode
    // Compressed words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,    // [31:0] out_word
    output logic             m_tlast     // last_word
);

    // Input register
    logic                 in_valid_reg;
    logic [1:0]           in_mode_reg;
    logic [31:0]          in_word_reg;

    // Encoder state: held tail words, their count and the merge state
    cbwe_pkg::enc_state_t st_reg;
    cbwe_pkg::enc_state_t st_next;
    logic [1:0]           cnt_reg;
    logic [1:0]           cnt_next;
    cbwe_pkg::word3_t     tail_reg;
    cbwe_pkg::word3_t     tail_next;

    cbwe_pkg::emit_t      emit;
    logic                 load_ok;
    logic                 step_fire;

    // A step runs once the result queue can take all of its words
    assign step_fire = in_valid_reg && load_ok;
    assign s_tready  = !in_valid_reg || step_fire;

    cbwe_step u_step (
        .mode      (in_mode_reg),
        .word      (in_word_reg),
        .st        (st_reg),
        .cnt       (cnt_reg),
        .tail      (tail_reg),
        .st_next   (st_next),
        .cnt_next  (cnt_next),
        .tail_next (tail_next),
        .emit      (emit)
    );

    cbwe_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_fire),
        .emit     (emit),
        .load_ok  (load_ok),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            st_reg       <= cbwe_pkg::ST_NONE;
            cnt_reg      <= 2'd0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step_fire) begin
                st_reg  <= st_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    // Payload; tail slots at or above cnt_reg are never read
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_mode_reg <= s_tuser;
            in_word_reg <= s_tdata;
        end
        if (step_fire) begin
            tail_reg <= tail_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/cbwe_checker.sv
// ----------------------------------------------------------------------------
// COMPAX bitmap word encoder - port checker
// Concurrent checks on the core's ports, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "compax_bitmap_word_encoder_core_assert.svh"

module cbwe_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tlast
);

    // A stalled output word holds
    `CBWE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output word changed while stalled")

    // Input backpressure only while output words are waiting
    `CBWE_ASSERT_IMP(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid, "input stalled with empty result queue")

    // After reset the core is empty and open for input
    `CBWE_ASSERT_NXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready, "core not empty after reset")

    // Input register emptied and result queue empty: no word can show next
    `CBWE_ASSERT_NXT(a_no_spont, aclk, aresetn, (!s_tvalid && s_tready) ##1 !m_tvalid, !m_tvalid, "output appeared without input")

endmodule

bind compax_bitmap_word_encoder_core cbwe_checker u_cbwe_checker (.*);

`default_nettype wire
